// ----- rtl/core/tdaf_pkg.sv -----
package tdaf_pkg;

    // Field widths of the words and the registers.
    localparam int TempWidth   = 12;
    localparam int TimeWidth   = 32;
    localparam int LevelWidth  = 2;
    localparam int InDataWidth = 48;
    localparam int OutDataWidth = 8;
    localparam int AddrWidth   = 4;
    localparam int BusWidth    = 32;

    // Alarm levels, also the state codes.
    localparam logic [LevelWidth-1:0] LVL_NORMAL     = 2'd0;
    localparam logic [LevelWidth-1:0] LVL_NORMAL_OUT = 2'd1;
    localparam logic [LevelWidth-1:0] LVL_PRE_ALARM  = 2'd2;
    localparam logic [LevelWidth-1:0] LVL_ALARM      = 2'd3;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_PRE_THRESH = 2'd0;
    localparam logic [1:0] REG_ALM_THRESH = 2'd1;
    localparam logic [1:0] REG_PRE_DWELL  = 2'd2;
    localparam logic [1:0] REG_ALM_DWELL  = 2'd3;

    // Register reset values.
    localparam logic signed [TempWidth-1:0] PRE_THRESH_RESET = 12'sd400;
    localparam logic signed [TempWidth-1:0] ALM_THRESH_RESET = 12'sd640;
    localparam logic [TimeWidth-1:0]        PRE_DWELL_RESET  = 32'd5000;
    localparam logic [TimeWidth-1:0]        ALM_DWELL_RESET  = 32'd5000;

    typedef logic [LevelWidth-1:0] level_t;

endpackage

// ----- rtl/core/temperature_dwell_alarm_fsm.sv -----
// The alarm level for a word appears on m_tdata in the cycle after the word is accepted.
// Throughput: one word per cycle; the whole state update is one pass of four compares and one
// 32-bit wrapping subtraction, and the output register takes a new word in the same cycle
// that its waiting result is taken, so only a stalled result side holds the input off.
// Reset (rst_n, asynchronous, active low) sets the level to normal, clears the dwell timer,
// empties the output register and loads the configuration registers with their defaults.
module temperature_dwell_alarm_fsm
    import tdaf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Input word.
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // [11:0] temperature, [43:12] now_ms, [44] device_out, [45] reset_pressed, [47:46] zero
    input  logic [InDataWidth-1:0]  s_tdata,
    // Result word.
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [1:0] alarm_level, [7:2] zero
    output logic [OutDataWidth-1:0] m_tdata,
    // Configuration port.
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [AddrWidth-1:0]    paddr,
    input  logic [BusWidth-1:0]     pwdata,
    output logic [BusWidth-1:0]     prdata,
    output logic                    pready
);

    // Configuration registers.
    logic signed [TempWidth-1:0] pre_thresh_reg;
    logic signed [TempWidth-1:0] alm_thresh_reg;
    logic [TimeWidth-1:0]        pre_dwell_reg;
    logic [TimeWidth-1:0]        alm_dwell_reg;

    // Alarm state and dwell timer.
    level_t               level_reg, level_next;
    logic                 dwell_active_reg, dwell_active_next;
    logic [TimeWidth-1:0] dwell_start_reg, dwell_start_next;

    // Output register.
    logic   out_valid_reg;
    level_t out_level_reg;

    // Unpacked input fields.
    logic signed [TempWidth-1:0] temperature;
    logic [TimeWidth-1:0]        now_ms;
    logic                        device_out;
    logic                        reset_pressed;

    logic                 accept;
    logic                 cfg_write;
    logic [1:0]           cfg_index;
    logic                 above_pre;
    logic                 above_alm;
    logic [TimeWidth-1:0] elapsed;
    logic                 check_above;
    logic                 check_exceed;
    level_t               fallback;

    assign temperature   = s_tdata[TempWidth-1:0];
    assign now_ms        = s_tdata[TempWidth +: TimeWidth];
    assign device_out    = s_tdata[TempWidth+TimeWidth];
    assign reset_pressed = s_tdata[TempWidth+TimeWidth+1];

    // Handshakes.
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(OutDataWidth-LevelWidth){1'b0}}, out_level_reg};
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_thresh_reg <= PRE_THRESH_RESET;
            alm_thresh_reg <= ALM_THRESH_RESET;
            pre_dwell_reg  <= PRE_DWELL_RESET;
            alm_dwell_reg  <= ALM_DWELL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PRE_THRESH: pre_thresh_reg <= pwdata[TempWidth-1:0];
                REG_ALM_THRESH: alm_thresh_reg <= pwdata[TempWidth-1:0];
                REG_PRE_DWELL:  pre_dwell_reg  <= pwdata;
                REG_ALM_DWELL:  alm_dwell_reg  <= pwdata;
                default:        ;
            endcase
        end
    end

    // Register readback, thresholds sign extended.
    always_comb
    begin
        unique case (cfg_index)
            REG_PRE_THRESH: prdata = {{(BusWidth-TempWidth){pre_thresh_reg[TempWidth-1]}},
                                      pre_thresh_reg};
            REG_ALM_THRESH: prdata = {{(BusWidth-TempWidth){alm_thresh_reg[TempWidth-1]}},
                                      alm_thresh_reg};
            REG_PRE_DWELL:  prdata = pre_dwell_reg;
            REG_ALM_DWELL:  prdata = alm_dwell_reg;
            default:        prdata = '0;
        endcase
    end

    // Threshold compares and the wrapping elapsed time.
    assign above_pre = temperature >= pre_thresh_reg;
    assign above_alm = temperature >= alm_thresh_reg;
    assign elapsed   = now_ms - dwell_start_reg;
    assign fallback  = device_out ? LVL_NORMAL_OUT : LVL_NORMAL;

    // The dwell timer watches threshold one in normal and threshold two in pre-alarm.
    always_comb
    begin
        if (level_reg == LVL_PRE_ALARM)
        begin
            check_above  = above_alm;
            check_exceed = elapsed > alm_dwell_reg;
        end
        else
        begin
            check_above  = above_pre;
            check_exceed = elapsed > pre_dwell_reg;
        end
    end

    // Next state for one tick.
    always_comb
    begin
        level_next        = level_reg;
        dwell_active_next = dwell_active_reg;
        dwell_start_next  = dwell_start_reg;
        unique case (level_reg)
            LVL_NORMAL_OUT:
            begin
                if (!device_out)
                begin
                    level_next = LVL_NORMAL;
                end
            end
            LVL_NORMAL, LVL_PRE_ALARM:
            begin
                // In normal, device out moves to normal-out unless pre-alarm is reached below.
                if (level_reg == LVL_NORMAL)
                begin
                    level_next = fallback;
                end
                if ((level_reg == LVL_PRE_ALARM) && !above_pre)
                begin
                    level_next        = fallback;
                    dwell_active_next = 1'b0;
                end
                else if (!check_above)
                begin
                    dwell_active_next = 1'b0;
                end
                else if (!dwell_active_reg)
                begin
                    dwell_start_next  = now_ms;
                    dwell_active_next = 1'b1;
                end
                else if (check_exceed)
                begin
                    dwell_active_next = 1'b0;
                    level_next = (level_reg == LVL_NORMAL) ? LVL_PRE_ALARM : LVL_ALARM;
                end
            end
            LVL_ALARM:
            begin
                if (reset_pressed)
                begin
                    level_next = fallback;
                end
            end
            default:
            begin
                level_next = LVL_NORMAL;
            end
        endcase
    end

    // State update on each accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg        <= LVL_NORMAL;
            dwell_active_reg <= 1'b0;
            dwell_start_reg  <= '0;
        end
        else if (accept)
        begin
            level_reg        <= level_next;
            dwell_active_reg <= dwell_active_next;
            dwell_start_reg  <= dwell_start_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_level_reg <= level_next;
        end
    end

endmodule

// ----- tb/tb_temperature_dwell_alarm_fsm.sv -----
module tb_temperature_dwell_alarm_fsm;
    import tdaf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    // [11:0] temperature, [43:12] now_ms, [44] device_out, [45] reset_pressed, [47:46] zero
    logic [InDataWidth-1:0]  s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    // [1:0] alarm_level, [7:2] zero
    logic [OutDataWidth-1:0] m_tdata;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [AddrWidth-1:0]    paddr = '0;
    logic [BusWidth-1:0]     pwdata = '0;
    logic [BusWidth-1:0]     prdata;
    logic                    pready;

    // Shadow copy of the configuration registers.
    logic signed [TempWidth-1:0] pre_thr = PRE_THRESH_RESET;
    logic signed [TempWidth-1:0] alm_thr = ALM_THRESH_RESET;
    logic [TimeWidth-1:0]        pre_dwell = PRE_DWELL_RESET;
    logic [TimeWidth-1:0]        alm_dwell = ALM_DWELL_RESET;

    // Predicted state of the alarm machine.
    level_t               lvl_now = LVL_NORMAL;
    bit                   dwell_on = 1'b0;
    logic [TimeWidth-1:0] dwell_t0 = '0;

    level_t               level_due[$];
    int                   err_count = 0;
    int                   sink_hold_cycles = 0;
    bit                   calm = 1'b0;
    logic [TimeWidth-1:0] clock_ms = '0;

    temperature_dwell_alarm_fsm u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Runs the dwell timer and reports whether the dwell has been exceeded.
    function automatic bit dwell_elapsed(bit above, logic [TimeWidth-1:0] now,
                                         logic [TimeWidth-1:0] limit);
        logic [TimeWidth-1:0] span;
        if (!above)
        begin
            dwell_on = 1'b0;
            return 1'b0;
        end
        if (!dwell_on)
        begin
            dwell_t0 = now;
            dwell_on = 1'b1;
            return 1'b0;
        end
        span = now - dwell_t0;
        if (span > limit)
        begin
            dwell_on = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advances the predicted machine by one tick and returns the new level.
    function automatic level_t advance_alarm_level(logic signed [TempWidth-1:0] temp,
                                                   logic [TimeWidth-1:0] now,
                                                   bit out, bit press);
        case (lvl_now)
            LVL_NORMAL_OUT:
            begin
                if (!out)
                    lvl_now = LVL_NORMAL;
            end
            LVL_NORMAL:
            begin
                // A pre-alarm reached in this tick wins over the out level.
                if (out)
                    lvl_now = LVL_NORMAL_OUT;
                if (dwell_elapsed(temp >= pre_thr, now, pre_dwell))
                    lvl_now = LVL_PRE_ALARM;
            end
            LVL_PRE_ALARM:
            begin
                if (temp < pre_thr)
                begin
                    lvl_now = out ? LVL_NORMAL_OUT : LVL_NORMAL;
                    dwell_on = 1'b0;
                end
                else if (dwell_elapsed(temp >= alm_thr, now, alm_dwell))
                    lvl_now = LVL_ALARM;
            end
            default:
            begin
                if (press)
                    lvl_now = out ? LVL_NORMAL_OUT : LVL_NORMAL;
            end
        endcase
        return lvl_now;
    endfunction

    function automatic logic signed [TempWidth-1:0] clamp_temp(int v);
        if (v > 2047)
            return 12'sd2047;
        if (v < -2048)
            return -12'sd2048;
        return v[TempWidth-1:0];
    endfunction

    // Offers one tick word and records its expected level once it is taken.
    task automatic send_tick(logic signed [TempWidth-1:0] temp, logic [TimeWidth-1:0] now,
                             bit out, bit press);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, press, out, now, temp};
        do
            @(posedge clk);
        while (!s_tready);
        level_due.push_back(advance_alarm_level(temp, now, out, press));
    endtask

    // Stops offering words and waits until every expected level has come back.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (level_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [BusWidth-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PRE_THRESH: pre_thr = value[TempWidth-1:0];
            REG_ALM_THRESH: alm_thr = value[TempWidth-1:0];
            REG_PRE_DWELL:  pre_dwell = value;
            default:        alm_dwell = value;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_config(int pthr, int athr, logic [TimeWidth-1:0] pdw,
                                logic [TimeWidth-1:0] adw);
        wait_drain();
        write_reg(REG_PRE_THRESH, pthr);
        write_reg(REG_ALM_THRESH, athr);
        write_reg(REG_PRE_DWELL, pdw);
        write_reg(REG_ALM_DWELL, adw);
    endtask

    // Random ticks in warm and cold spells, with a clock that mostly moves forward.
    task automatic run_random_phase(int count, int unsigned step_max);
        int anchor;
        int spell;
        logic signed [TempWidth-1:0] temp;
        spell = 0;
        anchor = 0;
        for (int n = 0; n < count; n++)
        begin
            if (spell == 0)
            begin
                spell = $urandom_range(3, 25);
                case ($urandom_range(0, 3))
                    0: anchor = int'((pre_thr < alm_thr) ? pre_thr : alm_thr)
                                - int'($urandom_range(1, 300));
                    1: anchor = int'(pre_thr);
                    2: anchor = int'(alm_thr);
                    default: anchor = int'((pre_thr > alm_thr) ? pre_thr : alm_thr);
                endcase
            end
            spell--;
            if ($urandom_range(0, 19) == 0)
                temp = TempWidth'($urandom());
            else
                temp = clamp_temp(anchor + int'($urandom_range(0, 24)) - 4);
            if ($urandom_range(0, 39) == 0)
                clock_ms = $urandom();
            else
                clock_ms = clock_ms + $urandom_range(0, step_max);
            send_tick(temp, clock_ms, $urandom_range(0, 6) == 0, $urandom_range(0, 9) == 0);
        end
    endtask

    task automatic test_directed();
        // Press outside alarm, coldest reading.
        send_tick(-12'sd2048, 32'h0000_0000, 1'b0, 1'b1);
        // Dwell start just before the clock wraps, then exactly the dwell, then one more.
        send_tick(12'sd400, 32'hFFFF_F000, 1'b0, 1'b0);
        send_tick(12'sd2047, 32'h0000_0388, 1'b0, 1'b0);
        send_tick(12'sd400, 32'h0000_0389, 1'b0, 1'b0);
        // Pre-alarm below the alarm threshold, then dwell toward alarm.
        send_tick(12'sd639, 32'h0000_0400, 1'b1, 1'b0);
        send_tick(12'sd640, 32'h0000_1000, 1'b0, 1'b0);
        send_tick(12'sd700, 32'h0000_2389, 1'b0, 1'b0);
        // Alarm holds without a press, then a press with the device out.
        send_tick(-12'sd2048, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_tick(12'sd2047, 32'h0000_0000, 1'b1, 1'b1);
        send_tick(12'sd2047, 32'h8000_0000, 1'b1, 1'b1);
        send_tick(12'sd399, 32'h8000_0001, 1'b0, 1'b0);
        // Dwell survives a visit to normal-out and then overrides the out level.
        send_tick(12'sd500, 32'h9000_0000, 1'b0, 1'b0);
        send_tick(12'sd500, 32'h9000_0001, 1'b1, 1'b0);
        send_tick(12'sd500, 32'h9000_2000, 1'b1, 1'b0);
        send_tick(12'sd500, 32'h9000_0002, 1'b0, 1'b0);
        send_tick(12'sd500, 32'h9000_1389, 1'b1, 1'b0);
        // Falling out of pre-alarm with the device out.
        send_tick(12'sd399, 32'h9000_1400, 1'b1, 1'b0);
        send_tick(12'sd0, 32'h9000_1401, 1'b0, 1'b0);
        // Straight to alarm, then a press with the device in.
        send_tick(12'sd2047, 32'hA000_0000, 1'b0, 1'b0);
        send_tick(12'sd2047, 32'hA000_1389, 1'b0, 1'b0);
        send_tick(12'sd2047, 32'hA000_138A, 1'b0, 1'b0);
        send_tick(12'sd2047, 32'hA000_2713, 1'b0, 1'b0);
        send_tick(12'sd2047, 32'hA000_2714, 1'b0, 1'b1);
        send_tick(12'sd2047, 32'hA000_2715, 1'b0, 1'b0);
    endtask

    task automatic test_config_extremes();
        apply_config(-2048, 2047, 32'd0, 32'hFFFF_FFFF);
        run_random_phase(50, 4);
        apply_config(2047, -2048, 32'hFFFF_FFFF, 32'd0);
        run_random_phase(50, 4);
    endtask

    task automatic test_reversed_thresholds();
        apply_config(600, 200, 32'd50, 32'd30);
        run_random_phase(150, 40);
    endtask

    task automatic test_short_dwells();
        apply_config(int'($urandom_range(0, 600)) - 300, int'($urandom_range(0, 600)) - 100,
                     $urandom_range(0, 20), $urandom_range(0, 20));
        run_random_phase(250, 10);
    endtask

    // The result side holds off long enough for the input side to stall.
    task automatic test_backpressure();
        apply_config(400, 640, 32'd5000, 32'd5000);
        sink_hold_cycles = 100;
        run_random_phase(40, 2000);
        wait_drain();
        run_random_phase(200, 2000);
    endtask

    task automatic test_random_configs();
        logic [TimeWidth-1:0] pdw;
        logic [TimeWidth-1:0] adw;
        for (int k = 0; k < 4; k++)
        begin
            pdw = (k == 0) ? $urandom() : $urandom_range(0, 3000);
            adw = (k == 0) ? $urandom() : $urandom_range(0, 3000);
            apply_config(int'($urandom_range(0, 4095)) - 2048,
                         int'($urandom_range(0, 4095)) - 2048, pdw, adw);
            if (k == 0)
                run_random_phase(140, 32'h2000_0000);
            else
                run_random_phase(140, ((pdw > adw) ? pdw : adw) / 3 + 1);
        end
    endtask

    task automatic test_calm_finish();
        apply_config(400, 640, 32'd5000, 32'd5000);
        calm = 1'b1;
        run_random_phase(250, 3000);
    endtask

    // Result side ready, with random stalls and the requested long hold-off.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (sink_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge clk);
                sink_hold_cycles = 0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Each accepted result word is matched against the oldest expected level.
    always @(posedge clk)
    begin : check_result
        level_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (level_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, m_tdata[LevelWidth-1:0]);
                err_count++;
            end
            else
            begin
                want = level_due.pop_front();
                if (m_tdata[LevelWidth-1:0] !== want)
                begin
                    $display("%0t: alarm_level mismatch, expected %0d, actual %0d",
                             $time, want, m_tdata[LevelWidth-1:0]);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        #3ms;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_reversed_thresholds();
        test_short_dwells();
        test_backpressure();
        test_random_configs();
        test_calm_finish();
        wait_drain();
        repeat (5) @(posedge clk);
        if (err_count == 0 && level_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
